>>> rtl/core/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// Widths, fixed-point constants and the tanh lookup table shared by the
// scaled tanh activation unit.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Table size; every index and interpolation width below follows from it.
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Port payload widths
    localparam int IN_W    = 16;
    localparam int ACT_W   = 16;
    localparam int SLOPE_W = 15;

    // Table span in Q5.10: 8448 = 33 * 2^8
    localparam int SPAN_X     = 8448;
    localparam int SPAN_SHIFT = 8;
    localparam int SPAN_ODD   = 33;

    localparam int AX_W   = IN_W;
    localparam int FRAC_W = $clog2(SPAN_X);
    localparam int REM_W  = FRAC_W - SPAN_SHIFT;
    localparam int P_W    = $clog2(SPAN_X * (TABLE_ENTRIES - 1));
    localparam int Q1_W   = P_W - SPAN_SHIFT;
    // Residual of a divide-by-33 after the estimate is below 66
    localparam int RES_W  = 7;

    // Q30 tanh values, one extra bit to hold exactly 1.0
    localparam int T_W    = 31;
    localparam int DIFF_W = 30;
    localparam int MUL_W  = DIFF_W + FRAC_W;
    localparam int Y_W    = MUL_W - SPAN_SHIFT;
    localparam int SUM_W  = Y_W + 1;

    localparam logic [T_W-1:0] ONE_Q30 = T_W'(64'd1 << 30);

    // Activation scaling: round(t * 17159 / (10000 * 2^16))
    localparam int ACTP_W    = 45;
    localparam int ACT_SHIFT = 20;
    localparam int U_W       = ACTP_W - ACT_SHIFT;
    localparam int ACT_RSH   = 34;
    localparam int PA_W      = 50;
    localparam int AE_W      = PA_W - ACT_RSH;
    localparam int AR_W      = 11;
    localparam int ACTM_W    = ACT_W - 1;
    localparam logic [ACTP_W-1:0] ACT_MUL   = ACTP_W'(17159);
    localparam logic [ACTP_W-1:0] ACT_RND   = ACTP_W'(64'd327680000);
    localparam logic [AR_W-1:0]   ACT_DIV   = AR_W'(625);
    localparam logic [PA_W-1:0]   ACT_RECIP = PA_W'(64'd27487790);

    // Slope scaling: round(s * 457573 / (400000 * 2^16)), 400000*2^16 = 3125*2^23
    localparam int SQ_W     = 61;
    localparam int WS_W     = 50;
    localparam int SL_SHIFT = 23;
    localparam int V_W      = WS_W - SL_SHIFT;
    localparam int SL_RSH   = 38;
    localparam int PS_W     = 54;
    localparam int SE_W     = PS_W - SL_RSH;
    localparam int SR_W     = 13;
    localparam logic [SQ_W-1:0] SQ_RND   = SQ_W'(64'd1 << 29);
    localparam logic [WS_W-1:0] SL_MUL   = WS_W'(457573);
    localparam logic [WS_W-1:0] SL_RND   = WS_W'(64'd13107200000);
    localparam logic [SR_W-1:0] SL_DIV   = SR_W'(3125);
    localparam logic [PS_W-1:0] SL_RECIP = PS_W'(64'd87960930);

    // Pipeline: 7 stages in the tanh core, 6 in the scaling back end
    localparam int PIPE_STAGES = 13;
    typedef logic [PIPE_STAGES-1:0] t_stage_en;

    typedef logic [T_W-1:0] t_tab [TABLE_ENTRIES];

    // Divide-by-33 estimate, x < 2^40. 1/33 = 31/1023 and 1/1023 is a
    // geometric series in 2^-10. Result is floor(x/33) or one less.
    localparam int DIV_W  = 40;
    localparam int DIVA_W = DIV_W + 5;
    localparam int DIVS_W = DIVA_W + 1;

    function automatic logic [DIV_W-1:0] div33_est(input logic [DIV_W-1:0] x);
        logic [DIVA_W-1:0] a;
        logic [DIVS_W-1:0] s;
        a = {x, 5'b0} - {5'b0, x};
        s = DIVS_W'(a) + DIVS_W'(a >> 10) + DIVS_W'(a >> 20)
          + DIVS_W'(a >> 30) + DIVS_W'(a >> 40);
        return DIV_W'(s >> 10);
    endfunction

    // Table construction, evaluated at elaboration only
    localparam longint unsigned TAB_ONE      = 64'd1 << 30;
    localparam longint unsigned TAB_HALF     = 64'd1 << 29;
    localparam longint unsigned TAB_DEN      = 64'd3 * 64'(TABLE_ENTRIES - 1) * 64'd65536;
    localparam longint unsigned TAB_DEN_HALF = TAB_DEN / 2;

    // Shift-subtract unsigned divide for the table build
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(v/2) in Q30 via exp(-v): 10-term series at v/64, then six squarings
    function automatic logic [T_W-1:0] tanh_point(input longint unsigned num);
        longint unsigned w;
        longint unsigned term;
        longint unsigned e;
        longint          sum;
        w    = div_u64((num << 30) + TAB_DEN_HALF, TAB_DEN);
        term = TAB_ONE;
        sum  = longint'(TAB_ONE);
        for (int k = 1; k <= 10; k++) begin
            term = (term * w + TAB_HALF) >> 30;
            term = div_u64(term, 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = longint'(sum);
        for (int k = 0; k < 6; k++) begin
            e = (e * e + TAB_HALF) >> 30;
        end
        if (e > TAB_ONE) begin
            e = TAB_ONE;
        end
        return T_W'(div_u64(((TAB_ONE - e) << 30) + ((TAB_ONE + e) >> 1), TAB_ONE + e));
    endfunction

    function automatic t_tab build_tab();
        t_tab tab;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tab[i] = tanh_point(64'd4 * 64'(i) * 64'(SPAN_X));
        end
        return tab;
    endfunction

    localparam t_tab TANH_TAB = build_tab();

endpackage
`default_nettype wire

>>> rtl/core/stc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_if
// Valid/ready stream interfaces for the activation unit: neuron sums in,
// activation and slope out.
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] weighted_input;

    modport source (output valid, output weighted_input, input ready);
    modport sink   (input valid, input weighted_input, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACT_W-1:0] activation;
    logic [SLOPE_W-1:0]      slope;

    modport source (output valid, output activation, output slope, input ready);
    modport sink   (input valid, input activation, input slope, output ready);
endinterface
`default_nettype wire

>>> rtl/core/scaled_tanh_activation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_tanh_activation_unit
// Scaled tanh activation 1.7159*tanh(2x/3) and its derivative, Q5.10 in,
// Q1.14 out.
// ----------------------------------------------------------------------------
// Takes one neuron sum per clock while input ready is high and returns one
// activation/slope pair per sum, in order. The 13-stage pipeline (7 stages of
// table lookup and interpolation, 6 of constant scaling) gives a throughput
// of one item per cycle when the output side is not stalled; it holds up to
// 13 items, and stalls on the output side fill empty stages before input
// ready drops. There is no configuration and no start-up sequence: the tanh
// table is constant logic.
// Inputs at or beyond |x| = 8.25 saturate to +-28113 with slope 0.
// ----------------------------------------------------------------------------
module scaled_tanh_activation_unit import stc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stc_in_if.sink    i_in,
    stc_out_if.source o_out
);

    t_stage_en      stage_en;
    logic           out_valid;
    logic [T_W-1:0] t_q30;
    logic           t_neg;

    stc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (out_valid),
        .o_stage_en  (stage_en)
    );

    stc_tanh_core u_core (
        .i_clk            (i_clk),
        .i_stage_en       (stage_en),
        .i_weighted_input (i_in.weighted_input),
        .o_t              (t_q30),
        .o_neg            (t_neg)
    );

    // stage 8: both products of t
    logic [ACTP_W-1:0] r8_am;
    logic [SQ_W-1:0]   r8_sq;
    logic              r8_neg;

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            r8_am  <= ACTP_W'(t_q30) * ACT_MUL;
            r8_sq  <= SQ_W'(t_q30) * SQ_W'(t_q30);
            r8_neg <= t_neg;
        end
    end

    // stage 9: rounding adds; s = 1 - t^2
    logic [ACTP_W-1:0] am_rnd;
    logic [SQ_W-1:0]   sq_rnd;
    logic [U_W-1:0]    r9_u;
    logic [T_W-1:0]    r9_s;
    logic              r9_neg;

    assign am_rnd = r8_am + ACT_RND;
    assign sq_rnd = r8_sq + SQ_RND;

    always_ff @(posedge i_clk) begin
        if (stage_en[8]) begin
            r9_u   <= am_rnd[ACTP_W-1:ACT_SHIFT];
            r9_s   <= ONE_Q30 - T_W'(sq_rnd >> 30);
            r9_neg <= r8_neg;
        end
    end

    // stage 10: reciprocal multiply for /625, slope numerator
    logic [PA_W-1:0] pa;
    logic [AE_W-1:0] r10_act_est;
    logic [U_W-1:0]  r10_u;
    logic [WS_W-1:0] r10_ws;
    logic            r10_neg;

    assign pa = PA_W'(r9_u) * ACT_RECIP;

    always_ff @(posedge i_clk) begin
        if (stage_en[9]) begin
            r10_act_est <= pa[PA_W-1:ACT_RSH];
            r10_u       <= r9_u;
            r10_ws      <= WS_W'(r9_s) * SL_MUL;
            r10_neg     <= r9_neg;
        end
    end

    // stage 11: correct activation quotient, round slope numerator
    logic [AR_W-1:0]   ares;
    logic              ainc;
    logic [WS_W-1:0]   ws_rnd;
    logic [ACTM_W-1:0] r11_act;
    logic [V_W-1:0]    r11_v;
    logic              r11_neg;

    always_comb begin
        ares   = r10_u[AR_W-1:0] - AR_W'(r10_act_est[AR_W-1:0] * ACT_DIV);
        ainc   = ares >= ACT_DIV;
        ws_rnd = r10_ws + SL_RND;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[10]) begin
            r11_act <= ACTM_W'(r10_act_est + AE_W'(ainc));
            r11_v   <= ws_rnd[WS_W-1:SL_SHIFT];
            r11_neg <= r10_neg;
        end
    end

    // stage 12: reciprocal multiply for /3125
    logic [PS_W-1:0]   ps;
    logic [SE_W-1:0]   r12_sl_est;
    logic [V_W-1:0]    r12_v;
    logic [ACTM_W-1:0] r12_act;
    logic              r12_neg;

    assign ps = PS_W'(r11_v) * SL_RECIP;

    always_ff @(posedge i_clk) begin
        if (stage_en[11]) begin
            r12_sl_est <= ps[PS_W-1:SL_RSH];
            r12_v      <= r11_v;
            r12_act    <= r11_act;
            r12_neg    <= r11_neg;
        end
    end

    // stage 13: correct slope quotient, restore sign
    logic [SR_W-1:0]         sres;
    logic                    sinc;
    logic [ACT_W-1:0]        act_u;
    logic signed [ACT_W-1:0] r13_activation;
    logic [SLOPE_W-1:0]      r13_slope;

    always_comb begin
        sres  = r12_v[SR_W-1:0] - SR_W'(r12_sl_est[SR_W-1:0] * SL_DIV);
        sinc  = sres >= SL_DIV;
        act_u = ACT_W'(r12_act);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[12]) begin
            r13_activation <= $signed(r12_neg ? (~act_u + ACT_W'(1)) : act_u);
            r13_slope      <= SLOPE_W'(r12_sl_est + SE_W'(sinc));
        end
    end

    assign o_out.valid      = out_valid;
    assign o_out.activation = r13_activation;
    assign o_out.slope      = r13_slope;

endmodule
`default_nettype wire

>>> rtl/core/stc_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pipe_ctrl
// Valid bits and per-stage load enables for the elastic pipeline. A stage
// loads when it is empty or its successor is loading, so bubbles collapse.
// ----------------------------------------------------------------------------
module stc_pipe_ctrl import stc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_stage_en o_stage_en
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES:0]   rdy;
    logic [PIPE_STAGES-1:0] upstream;

    always_comb begin
        rdy[PIPE_STAGES] = i_out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    assign upstream = {r_valid[PIPE_STAGES-2:0], i_in_valid};

    always_comb begin
        n_valid = r_valid;
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (rdy[k]) begin
                n_valid[k] = upstream[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_valid[PIPE_STAGES-1];
    assign o_stage_en  = rdy[PIPE_STAGES-1:0];

endmodule
`default_nettype wire

>>> rtl/core/stc_tanh_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_tanh_core
// Seven-stage tanh(2|x|/3) evaluation in Q30: magnitude and table position,
// index split by 33, table read, interpolation product, rounded divide,
// final sum with saturation.
// ----------------------------------------------------------------------------
module stc_tanh_core import stc_pkg::*; (
    input  logic                   i_clk,
    input  t_stage_en              i_stage_en,
    input  logic signed [IN_W-1:0] i_weighted_input,
    output logic [T_W-1:0]         o_t,
    output logic                   o_neg
);

    // stage 1: magnitude, saturation flag, position in table units
    logic [AX_W-1:0]  raw;
    logic [AX_W-1:0]  ax;
    logic             n1_neg;
    logic             n1_sat;
    logic [P_W-1:0]   n1_p;
    logic             r1_neg;
    logic             r1_sat;
    logic [P_W-1:0]   r1_p;

    always_comb begin
        raw    = $unsigned(i_weighted_input);
        n1_neg = raw[AX_W-1];
        ax     = n1_neg ? (~raw + AX_W'(1)) : raw;
        n1_sat = ax >= AX_W'(SPAN_X);
        n1_p   = P_W'(ax[FRAC_W-1:0]) * P_W'(TABLE_ENTRIES - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r1_neg <= n1_neg;
            r1_sat <= n1_sat;
            r1_p   <= n1_p;
        end
    end

    // stage 2: index estimate, (p >> 8) / 33
    logic [Q1_W-1:0]       q1;
    logic [Q1_W-1:0]       n2_est;
    logic [Q1_W-1:0]       r2_q;
    logic [Q1_W-1:0]       r2_est;
    logic [SPAN_SHIFT-1:0] r2_plow;
    logic                  r2_neg;
    logic                  r2_sat;

    assign q1     = r1_p[P_W-1:SPAN_SHIFT];
    assign n2_est = Q1_W'(div33_est(DIV_W'(q1)));

    always_ff @(posedge i_clk) begin
        if (i_stage_en[1]) begin
            r2_q    <= q1;
            r2_est  <= n2_est;
            r2_plow <= r1_p[SPAN_SHIFT-1:0];
            r2_neg  <= r1_neg;
            r2_sat  <= r1_sat;
        end
    end

    // stage 3: correct the estimate, form index and fraction
    logic [RES_W-1:0]  res1;
    logic              inc1;
    logic [RES_W-1:0]  rem1;
    logic [Q1_W-1:0]   idx_full;
    logic [IDX_W-1:0]  n3_idx;
    logic [FRAC_W-1:0] n3_frac;
    logic [IDX_W-1:0]  r3_idx;
    logic [FRAC_W-1:0] r3_frac;
    logic              r3_neg;
    logic              r3_sat;

    always_comb begin
        // residual is small, so only the low bits matter
        res1     = r2_q[RES_W-1:0] - RES_W'(r2_est[RES_W-1:0] * RES_W'(SPAN_ODD));
        inc1     = res1 >= RES_W'(SPAN_ODD);
        rem1     = inc1 ? (res1 - RES_W'(SPAN_ODD)) : res1;
        idx_full = r2_est + Q1_W'(inc1);
        n3_idx   = (idx_full > Q1_W'(TABLE_ENTRIES - 2)) ? IDX_W'(TABLE_ENTRIES - 2)
                                                         : idx_full[IDX_W-1:0];
        n3_frac  = {rem1[REM_W-1:0], r2_plow};
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[2]) begin
            r3_idx  <= n3_idx;
            r3_frac <= n3_frac;
            r3_neg  <= r2_neg;
            r3_sat  <= r2_sat;
        end
    end

    // stage 4: read both neighbors
    logic [IDX_W-1:0]  idx_hi;
    logic [T_W-1:0]    tab_lo;
    logic [T_W-1:0]    tab_hi;
    logic [DIFF_W-1:0] n4_diff;
    logic [T_W-1:0]    r4_lo;
    logic [DIFF_W-1:0] r4_diff;
    logic [FRAC_W-1:0] r4_frac;
    logic              r4_neg;
    logic              r4_sat;

    always_comb begin
        idx_hi  = r3_idx + IDX_W'(1);
        tab_lo  = TANH_TAB[r3_idx];
        tab_hi  = TANH_TAB[idx_hi];
        n4_diff = (tab_hi > tab_lo) ? DIFF_W'(tab_hi - tab_lo) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[3]) begin
            r4_lo   <= tab_lo;
            r4_diff <= n4_diff;
            r4_frac <= r3_frac;
            r4_neg  <= r3_neg;
            r4_sat  <= r3_sat;
        end
    end

    // stage 5: slope times fraction, rounded, pre-shifted by 2^8
    logic [MUL_W-1:0] prod;
    logic [Y_W-1:0]   r5_y;
    logic [T_W-1:0]   r5_lo;
    logic             r5_neg;
    logic             r5_sat;

    assign prod = MUL_W'(r4_diff) * MUL_W'(r4_frac) + MUL_W'(SPAN_X / 2);

    always_ff @(posedge i_clk) begin
        if (i_stage_en[4]) begin
            r5_y   <= prod[MUL_W-1:SPAN_SHIFT];
            r5_lo  <= r4_lo;
            r5_neg <= r4_neg;
            r5_sat <= r4_sat;
        end
    end

    // stage 6: divide-by-33 estimate
    logic [Y_W-1:0] r6_est;
    logic [Y_W-1:0] r6_y;
    logic [T_W-1:0] r6_lo;
    logic           r6_neg;
    logic           r6_sat;

    always_ff @(posedge i_clk) begin
        if (i_stage_en[5]) begin
            r6_est <= Y_W'(div33_est(DIV_W'(r5_y)));
            r6_y   <= r5_y;
            r6_lo  <= r5_lo;
            r6_neg <= r5_neg;
            r6_sat <= r5_sat;
        end
    end

    // stage 7: correct, add to the lower point, clamp to 1.0
    logic [RES_W-1:0] res2;
    logic             inc2;
    logic [SUM_W-1:0] sum;
    logic [T_W-1:0]   n7_t;
    logic [T_W-1:0]   r7_t;
    logic             r7_neg;

    always_comb begin
        res2 = r6_y[RES_W-1:0] - RES_W'(r6_est[RES_W-1:0] * RES_W'(SPAN_ODD));
        inc2 = res2 >= RES_W'(SPAN_ODD);
        sum  = SUM_W'(r6_lo) + SUM_W'(r6_est) + SUM_W'(inc2);
        if (r6_sat || (sum > SUM_W'(ONE_Q30))) begin
            n7_t = ONE_Q30;
        end else begin
            n7_t = sum[T_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[6]) begin
            r7_t   <= n7_t;
            r7_neg <= r6_neg;
        end
    end

    assign o_t   = r7_t;
    assign o_neg = r7_neg;

endmodule
`default_nettype wire

>>> rtl/core/stc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks for the activation unit: occupancy bound, no result
// without a pending input, stall behavior, and backpressure passthrough.
// ----------------------------------------------------------------------------
module stc_checker import stc_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [ACT_W-1:0] i_activation,
    input wire logic [SLOPE_W-1:0]      i_slope
);

    localparam int CNT_W = $clog2(PIPE_STAGES + 2) + 1;

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_comb begin
        n_inflight = r_inflight;
        if (in_xfer && !out_xfer) begin
            n_inflight = r_inflight + CNT_W'(1);
        end else if (out_xfer && !in_xfer) begin
            n_inflight = r_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // items held never exceed the pipeline depth
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(PIPE_STAGES))
        else $error("more items in flight than pipeline stages");

    // a result is only offered while an accepted input is outstanding
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_inflight != '0))
        else $error("result offered with no input outstanding");

    // with the output side draining, the input side never stalls
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_activation) && $stable(i_slope)))
        else $error("stalled result changed or dropped");

endmodule

bind scaled_tanh_activation_unit stc_checker u_stc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_activation (o_out.activation),
    .i_slope      (o_out.slope)
);
`default_nettype wire

>>> tb/stc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_scoreboard
// Scoreboard for the scaled tanh activation unit. It predicts the activation
// and slope of every neuron sum that the unit accepts, then compares the
// pairs that the unit returns against those predictions, oldest first.
// ----------------------------------------------------------------------------
module stc_scoreboard import stc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    stc_in_if    i_in,
    stc_out_if   i_out,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked
);

    typedef longint unsigned t_u64;

    typedef struct {
        logic signed [IN_W-1:0]  x;
        logic signed [ACT_W-1:0] activation;
        logic [SLOPE_W-1:0]      slope;
    } t_act_pair;

    localparam t_u64 Q30_UNIT = 64'd1 << 30;
    localparam t_u64 Q30_HALF = 64'd1 << 29;

    t_u64      tanh_knot [TABLE_ENTRIES];
    t_act_pair pending_pairs [$];
    int        fails   = 0;
    int        checked = 0;

    // tanh(v/2) in Q30, v = 64*num / (3*(N-1)*2^16). exp(-v) comes from a
    // 10-term series at v/64 that is then squared six times.
    function automatic t_u64 knot_q30(input t_u64 num);
        t_u64   den;
        t_u64   w;
        t_u64   term;
        t_u64   e;
        longint acc;
        den  = 64'd3 * t_u64'(TABLE_ENTRIES - 1) * 64'd65536;
        w    = ((num << 30) + den / 2) / den;
        term = Q30_UNIT;
        acc  = longint'(Q30_UNIT);
        for (int k = 1; k <= 10; k++) begin
            term = ((term * w + Q30_HALF) >> 30) / t_u64'(k);
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        e = (acc < 0) ? 64'd0 : t_u64'(acc);
        repeat (6) e = (e * e + Q30_HALF) >> 30;
        if (e > Q30_UNIT) begin
            e = Q30_UNIT;
        end
        return (((Q30_UNIT - e) << 30) + (Q30_UNIT + e) / 2) / (Q30_UNIT + e);
    endfunction

    function automatic t_act_pair lecun_pair(input logic signed [IN_W-1:0] x);
        t_act_pair        r;
        t_u64             mag;
        t_u64             p;
        t_u64             idx;
        t_u64             frac;
        t_u64             lo;
        t_u64             hi;
        t_u64             t;
        t_u64             act;
        t_u64             s;
        t_u64             slope;
        logic [ACT_W-1:0] act_bits;
        // -32768 becomes magnitude 32768 and saturates
        mag = t_u64'(x[IN_W-1:0]);
        if (x[IN_W-1]) begin
            mag = (64'd1 << IN_W) - mag;
        end
        if (mag >= SPAN_X) begin
            t = Q30_UNIT;
        end else begin
            p    = mag * t_u64'(TABLE_ENTRIES - 1);
            idx  = p / SPAN_X;
            frac = p % SPAN_X;
            if (idx > TABLE_ENTRIES - 2) begin
                idx = TABLE_ENTRIES - 2;
            end
            lo = tanh_knot[idx];
            hi = tanh_knot[idx + 1];
            if (hi < lo) begin
                hi = lo;
            end
            t = lo + ((hi - lo) * frac + SPAN_X / 2) / SPAN_X;
            if (t > Q30_UNIT) begin
                t = Q30_UNIT;
            end
        end
        act      = (t * 64'd17159 + 64'd327680000) / 64'd655360000;
        s        = Q30_UNIT - ((t * t + Q30_HALF) >> 30);
        slope    = (s * 64'd457573 + 64'd13107200000) / 64'd26214400000;
        act_bits = act[ACT_W-1:0];
        r.x          = x;
        r.activation = x[IN_W-1] ? -act_bits : act_bits;
        r.slope      = slope[SLOPE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fails++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tanh_knot[i] = knot_q30(64'd4 * t_u64'(i) * t_u64'(SPAN_X));
        end
    end

    always @(posedge i_clk) begin
        t_act_pair want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                pending_pairs.push_back(lecun_pair(i_in.weighted_input));
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_pairs.size() == 0) begin
                    report_mismatch($sformatf("pair with no input: act=%0d slope=%0d",
                                              i_out.activation, i_out.slope));
                end else begin
                    want = pending_pairs.pop_front();
                    checked++;
                    if (i_out.activation !== want.activation) begin
                        report_mismatch($sformatf("x=%0d activation got %0d want %0d",
                                                  want.x, i_out.activation, want.activation));
                    end
                    if (i_out.slope !== want.slope) begin
                        report_mismatch($sformatf("x=%0d slope got %0d want %0d",
                                                  want.x, i_out.slope, want.slope));
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= pending_pairs.size();
        o_checked     <= checked;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the scaled tanh activation unit. Corner sums first, then
// random sums weighted toward the table span, with random gaps on the input,
// random and long stalls on the output, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb;
    import stc_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_LIMIT = 2000;
    localparam int CORNER_SUMS [22] = '{
        0, 1, -1, 32767, -32768, 8447, -8447, 8448, -8448, 8449, -8449,
        33, -33, 34, 1024, -1024, 4224, -4224, 16384, -16384, 12345, -21846
    };

    logic clk = 1'b0;
    logic rst_n;
    bit   tx_idle_en;
    bit   rx_idle_en;
    bit   hold_req;
    int   sums_sent      = 0;
    int   sums_saturated = 0;
    int   holds_done     = 0;
    int   input_stalls   = 0;
    int   fail_count;
    int   outstanding;
    int   checked;

    stc_in_if  in_ch ();
    stc_out_if out_ch ();

    scaled_tanh_activation_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    stc_scoreboard chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #2 clk = ~clk;

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && in_ch.valid && !in_ch.ready) begin
            input_stalls++;
        end
    end

    // Output side: short random stalls, plus one long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 6) == 0) begin
                    stall_left = $urandom_range(1, 4);
                end
            end
        end
    end

    function automatic logic signed [IN_W-1:0] random_sum();
        int mag;
        case ($urandom_range(0, 9))
            0, 1:    return IN_W'($urandom);
            2:       mag = SPAN_X - 4 + $urandom_range(0, 8);
            default: mag = $urandom_range(0, SPAN_X - 1);
        endcase
        return ($urandom_range(0, 1) != 0) ? IN_W'(-mag) : IN_W'(mag);
    endfunction

    // Called at a rising edge; returns at the edge of the transfer
    task automatic send_sum(input logic signed [IN_W-1:0] x);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.weighted_input <= x;
        do @(posedge clk); while (!in_ch.ready);
        sums_sent++;
        if (x >= SPAN_X || x <= -SPAN_X) begin
            sums_saturated++;
        end
    endtask

    initial begin
        int drain;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.weighted_input = '0;
        tx_idle_en           = 1'b0;
        rx_idle_en           = 1'b0;
        hold_req             = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (CORNER_SUMS[i]) begin
            send_sum(IN_W'(CORNER_SUMS[i]));
        end

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (300) send_sum(random_sum());

        // Back-pressure: input keeps offering while the output is held off
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (100) send_sum(random_sum());

        tx_idle_en = 1'b1;
        repeat (450) send_sum(random_sum());

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (150) send_sum(random_sum());
        in_ch.valid <= 1'b0;

        drain = 0;
        do begin
            @(posedge clk);
            drain++;
        end while (outstanding != 0 && drain < DRAIN_LIMIT);
        repeat (2 * PIPE_STAGES) @(posedge clk);

        if (outstanding != 0) begin
            $display("%0d expected pairs never came out", outstanding);
        end
        $display("Sent %0d neuron sums (%0d saturating), checked %0d activation/slope pairs",
                 sums_sent, sums_saturated, checked);
        $display("Input stalled %0d cycles across %0d long output hold(s)",
                 input_stalls, holds_done);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
